@@ sv/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the serial packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int LEN_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [LEN_W-1:0] LEN_MAX  = 31'h7FFF_FFFF;
    localparam logic [7:0]       NEWLINE  = 8'h0A;
    localparam logic [7:0]       HDR_MAX  = 8'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_BYTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_LE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 3'd5;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_LINE = 2'd2,
        MODE_BAD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_NEED  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        t_mode            mode;
        logic [15:0]      fixed_length;
        logic [7:0]       header_bytes;
        logic             header_le;
        logic [LEN_W-1:0] max_payload;
        logic [LEN_W-1:0] line_limit;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] length;
        logic             truncated;
    } t_result;

endpackage

@@ sv/spf_channels.sv @@
// ----------------------------------------------------------------------------
// spf_channels
// Valid/ready channels of the framer: byte input, result output, config write.
// ----------------------------------------------------------------------------
interface spf_rx_if import spf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spf_res_if import spf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       frame_status;
    logic [LEN_W-1:0] packet_length;
    logic             was_truncated;

    modport source (output valid, output frame_status, output packet_length,
                    output was_truncated, input ready);
    modport sink   (input valid, input frame_status, input packet_length,
                    input was_truncated, output ready);
endinterface

interface spf_cfg_if import spf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/serial_packet_framer.sv @@
// ----------------------------------------------------------------------------
// serial_packet_framer
// Byte-stream packet framer: raw fixed length, length prefix, or line mode.
//
//   channel  dir  fields                                          handshake
//   i_rx     in   rx_byte[7:0]                                    valid/ready
//   o_res    out  frame_status[1:0] packet_length[30:0]
//                 was_truncated                                   valid/ready
//   i_cfg    in   index[2:0] data[30:0]                           valid/ready
//
// One byte per cycle sustained while the result side is ready; a byte's result
// is offered after it passes the input register, then the result register.
// Synchronous active-low reset clears the counters and loads register defaults.
// A stalled result holds in the result register while the input register still
// takes one more byte; the config port is always ready.
// ----------------------------------------------------------------------------
module serial_packet_framer import spf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spf_rx_if.sink    i_rx,
    spf_res_if.source o_res,
    spf_cfg_if.sink   i_cfg
);

    t_cfg       w_cfg;
    t_result    w_result;
    logic       w_advance;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    spf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    spf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_advance),
        .i_rx_byte (r_in_byte),
        .o_result  (w_result)
    );

    // move the held byte into the result register when that slot frees up
    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.frame_status  = r_out.status;
    assign o_res.packet_length = r_out.length;
    assign o_res.was_truncated = r_out.truncated;

    a_advance_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded on advance");

    a_full_input_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !i_rx.ready)
        else $error("input register overwritten while held");

    a_advance_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> r_in_valid)
        else $error("advance without a held byte");

endmodule

@@ sv/spf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// spf_cfg_regs
// Configuration register bank, written through the config channel.
// ----------------------------------------------------------------------------
module spf_cfg_regs import spf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spf_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FRAME_MODE:  n_cfg.mode         = t_mode'(i_cfg.data[1:0]);
                REG_FIXED_LEN:   n_cfg.fixed_length = i_cfg.data[15:0];
                REG_HDR_BYTES:   n_cfg.header_bytes = i_cfg.data[7:0];
                REG_HDR_LE:      n_cfg.header_le    = i_cfg.data[0];
                REG_MAX_PAYLOAD: n_cfg.max_payload  = i_cfg.data[LEN_W-1:0];
                REG_LINE_LIMIT:  n_cfg.line_limit   = i_cfg.data[LEN_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_RAW;
            r_cfg.fixed_length <= '0;
            r_cfg.header_bytes <= 8'd1;
            r_cfg.header_le    <= 1'b0;
            r_cfg.max_payload  <= '0;
            r_cfg.line_limit   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/spf_core.sv @@
// ----------------------------------------------------------------------------
// spf_core
// Packet counters and per-byte framing decision for all three modes.
// ----------------------------------------------------------------------------
module spf_core import spf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    logic [LEN_W-1:0] r_bytes_seen;
    logic [31:0]      r_len_acc;
    logic [LEN_W-1:0] r_target_total;
    logic             r_target_known;

    logic [LEN_W-1:0] n_bytes_seen;
    logic [31:0]      n_len_acc;
    logic [LEN_W-1:0] n_target_total;
    logic             n_target_known;

    logic [LEN_W-1:0] w_n;
    logic [LEN_W-1:0] w_hl;
    logic [LEN_W-1:0] w_fl;
    logic [2:0]       w_le_idx;
    logic [31:0]      w_le_term;
    logic [31:0]      w_acc;
    logic [32:0]      w_total;
    logic             w_take_hdr;
    t_result          w_res;

    // saturating byte count including this byte
    assign w_n  = (r_bytes_seen == LEN_MAX) ? r_bytes_seen : r_bytes_seen + 1'b1;
    assign w_hl = {{(LEN_W-8){1'b0}}, i_cfg.header_bytes};
    assign w_fl = {{(LEN_W-16){1'b0}}, i_cfg.fixed_length};

    assign w_take_hdr = (w_n <= w_hl) && (w_n <= {{(LEN_W-8){1'b0}}, HDR_MAX});
    assign w_le_idx   = w_n[2:0] - 3'd1;
    // bytes past the fourth land above the kept 32 bits
    assign w_le_term  = {24'd0, i_rx_byte} << {w_le_idx, 3'b000};

    always_comb begin
        w_acc = r_len_acc;
        if (w_take_hdr) begin
            if (i_cfg.header_le) begin
                w_acc = r_len_acc | w_le_term;
            end else begin
                w_acc = {r_len_acc[23:0], i_rx_byte};
            end
        end
    end

    assign w_total = {1'b0, w_acc} + {25'd0, i_cfg.header_bytes};

    always_comb begin
        w_res          = '{status: ST_NEED, length: '0, truncated: 1'b0};
        n_bytes_seen   = w_n;
        n_len_acc      = r_len_acc;
        n_target_total = r_target_total;
        n_target_known = r_target_known;

        case (i_cfg.mode)
            MODE_RAW: begin
                if (i_cfg.fixed_length == 16'd0) begin
                    w_res.status = ST_DONE;
                    w_res.length = w_n;
                end else if (i_cfg.max_payload != '0 && w_fl > i_cfg.max_payload) begin
                    w_res.status = ST_ERROR;
                end else if (w_n >= w_fl) begin
                    w_res.status = ST_DONE;
                    w_res.length = w_fl;
                end
            end
            MODE_LEN: begin
                if (!r_target_known) begin
                    n_len_acc = w_acc;
                    if (w_n < w_hl) begin
                        w_res.status = ST_NEED;
                    end else if (i_cfg.header_bytes == 8'd0 || i_cfg.header_bytes > HDR_MAX) begin
                        w_res.status = ST_ERROR;
                    end else if (i_cfg.max_payload != '0
                                 && w_acc > {1'b0, i_cfg.max_payload}) begin
                        w_res.status = ST_ERROR;
                    end else if (w_total[32:31] != 2'b00) begin
                        w_res.status = ST_ERROR;
                    end else begin
                        n_target_total = w_total[LEN_W-1:0];
                        n_target_known = 1'b1;
                        if (w_n >= w_total[LEN_W-1:0]) begin
                            w_res.status = ST_DONE;
                            w_res.length = w_total[LEN_W-1:0];
                        end
                    end
                end else if (w_n >= r_target_total) begin
                    w_res.status = ST_DONE;
                    w_res.length = r_target_total;
                end
            end
            MODE_LINE: begin
                if (i_rx_byte == NEWLINE) begin
                    w_res.status = ST_DONE;
                    if (i_cfg.line_limit != '0 && w_n > i_cfg.line_limit) begin
                        w_res.length    = i_cfg.line_limit;
                        w_res.truncated = 1'b1;
                    end else begin
                        w_res.length = w_n;
                    end
                end else if (i_cfg.line_limit != '0 && w_n >= i_cfg.line_limit) begin
                    w_res.status    = ST_DONE;
                    w_res.length    = i_cfg.line_limit;
                    w_res.truncated = 1'b1;
                end
            end
            default: begin
                w_res.status = ST_ERROR;
            end
        endcase

        // completion or error starts a new packet
        if (w_res.status != ST_NEED) begin
            n_bytes_seen   = '0;
            n_len_acc      = '0;
            n_target_total = '0;
            n_target_known = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen   <= '0;
            r_len_acc      <= '0;
            r_target_total <= '0;
            r_target_known <= 1'b0;
        end else if (i_advance) begin
            r_bytes_seen   <= n_bytes_seen;
            r_len_acc      <= n_len_acc;
            r_target_total <= n_target_total;
            r_target_known <= n_target_known;
        end
    end

    assign o_result = w_res;

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_res.status != ST_NEED) |=> (r_bytes_seen == '0 && !r_target_known))
        else $error("counters not cleared after packet end");

    a_done_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.status == ST_DONE) |-> (w_res.length != '0))
        else $error("completed packet with zero length");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.status != ST_DONE) |-> (w_res.length == '0 && !w_res.truncated))
        else $error("length or truncation set without completion");

endmodule

@@ tb/serial_packet_framer_tb.sv @@
// ----------------------------------------------------------------------------
// serial_packet_framer_tb
// Self-checking bench for the packet framer. A short scripted sequence covers
// reset defaults, field extremes and the error cases of each mode. Random
// phases then reconfigure the block and stream raw packets, length-prefixed
// packets and lines, some malformed, mixed with noise. Each result is checked
// against a script entry or the in-bench framer model. Both handshake sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module serial_packet_framer_tb;
    import spf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_BYTES = 1250;
    localparam int SQUEEZE_AT = 300;
    localparam int SQUEEZE_CYC = 400;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [7:0]            rx;
        bit                    typed;
        t_result               want;
    } t_script_row;

    logic clk;
    logic rst_n;

    spf_rx_if  rx_ch ();
    spf_res_if res_ch ();
    spf_cfg_if cfg_ch ();

    serial_packet_framer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // framer model state and register copy
    t_cfg        cur_cfg;
    logic [31:0] cnt_seen;
    logic [63:0] hdr_value;
    logic [31:0] pkt_total;
    bit          pkt_total_known;

    t_result     pending_frames[$];
    t_script_row script[$];
    int          frames_checked;
    int          mismatches;
    int          bytes_sent;
    bit          calm;
    bit          squeeze_done;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void model_reset();
        cur_cfg.mode         = MODE_RAW;
        cur_cfg.fixed_length = '0;
        cur_cfg.header_bytes = 8'd1;
        cur_cfg.header_le    = 1'b0;
        cur_cfg.max_payload  = '0;
        cur_cfg.line_limit   = '0;
        cnt_seen        = '0;
        hdr_value       = '0;
        pkt_total       = '0;
        pkt_total_known = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_MODE:  cur_cfg.mode         = t_mode'(val[1:0]);
            REG_FIXED_LEN:   cur_cfg.fixed_length = val[15:0];
            REG_HDR_BYTES:   cur_cfg.header_bytes = val[7:0];
            REG_HDR_LE:      cur_cfg.header_le    = val[0];
            REG_MAX_PAYLOAD: cur_cfg.max_payload  = val[LEN_W-1:0];
            REG_LINE_LIMIT:  cur_cfg.line_limit   = val[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the framer state by one byte and return its result.
    function automatic t_result predict_frame(logic [7:0] b);
        t_result     r;
        logic [31:0] n;
        logic [31:0] hl;
        logic [31:0] plen;
        logic [63:0] total;
        bit          decided;
        r.status    = ST_NEED;
        r.length    = '0;
        r.truncated = 1'b0;
        decided     = 1'b0;
        if (cnt_seen < {1'b0, LEN_MAX})
            cnt_seen = cnt_seen + 32'd1;
        n = cnt_seen;
        case (cur_cfg.mode)
            MODE_RAW: begin
                if (cur_cfg.fixed_length == 0) begin
                    r.status = ST_DONE;
                    r.length = n[LEN_W-1:0];
                end else if (cur_cfg.max_payload != 0 &&
                             cur_cfg.fixed_length > cur_cfg.max_payload) begin
                    r.status = ST_ERROR;
                end else if (n >= cur_cfg.fixed_length) begin
                    r.status = ST_DONE;
                    r.length = LEN_W'(cur_cfg.fixed_length);
                end
            end
            MODE_LEN: begin
                if (!pkt_total_known) begin
                    hl = {24'd0, cur_cfg.header_bytes};
                    if (n <= hl && n <= 32'd8) begin
                        if (cur_cfg.header_le)
                            hdr_value = hdr_value | ({56'd0, b} << (8 * (n - 1)));
                        else
                            hdr_value = {hdr_value[55:0], b};
                    end
                    plen  = hdr_value[31:0];
                    total = {32'd0, hl} + {32'd0, plen};
                    if (n < hl) begin
                        decided = 1'b1;
                    end else if (hl < 1 || hl > 8) begin
                        r.status = ST_ERROR;
                        decided  = 1'b1;
                    end else if (cur_cfg.max_payload != 0 &&
                                 plen > {1'b0, cur_cfg.max_payload}) begin
                        r.status = ST_ERROR;
                        decided  = 1'b1;
                    end else if (total > {33'd0, LEN_MAX}) begin
                        r.status = ST_ERROR;
                        decided  = 1'b1;
                    end else begin
                        pkt_total       = total[31:0];
                        pkt_total_known = 1'b1;
                    end
                end
                if (!decided && n >= pkt_total) begin
                    r.status = ST_DONE;
                    r.length = pkt_total[LEN_W-1:0];
                end
            end
            MODE_LINE: begin
                if (b == NEWLINE) begin
                    r.status = ST_DONE;
                    if (cur_cfg.line_limit != 0 && n > {1'b0, cur_cfg.line_limit}) begin
                        r.length    = cur_cfg.line_limit;
                        r.truncated = 1'b1;
                    end else begin
                        r.length = n[LEN_W-1:0];
                    end
                end else if (cur_cfg.line_limit != 0 &&
                             n >= {1'b0, cur_cfg.line_limit}) begin
                    r.status    = ST_DONE;
                    r.length    = cur_cfg.line_limit;
                    r.truncated = 1'b1;
                end
            end
            default: r.status = ST_ERROR;
        endcase
        if (r.status != ST_NEED) begin
            cnt_seen        = '0;
            hdr_value       = '0;
            pkt_total       = '0;
            pkt_total_known = 1'b0;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_rx(input logic [7:0] b, input bit typed, input t_result want);
        int      gap;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!(rx_ch.valid && rx_ch.ready))
            @(posedge clk);
        r = predict_frame(b);
        pending_frames.push_back(typed ? want : r);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_rx(b, 1'b0, '0);
    endtask

    // drop the request and let every result come back
    task automatic quiesce();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_script_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = val;
        script.push_back(row);
    endfunction

    function automatic void add_rx(logic [7:0] b, bit typed = 1'b0,
                                   t_status st = ST_NEED, logic [LEN_W-1:0] len = '0,
                                   logic tr = 1'b0);
        t_script_row row;
        row                = '0;
        row.rx             = b;
        row.typed          = typed;
        row.want.status    = st;
        row.want.length    = len;
        row.want.truncated = tr;
        script.push_back(row);
    endfunction

    task automatic send_len_packet();
        logic [63:0] val;
        logic [31:0] plen;
        logic [7:0]  b;
        int          hl;
        int          r;
        hl = (cur_cfg.header_bytes == 0) ? 1 : int'(cur_cfg.header_bytes);
        r  = $urandom_range(0, 99);
        if (r < 75)
            plen = $urandom_range(0, 24);
        else if (r < 88)
            plen = $urandom_range(0, 60);
        else
            plen = 32'h8000_0000 | $urandom;
        val = {$urandom, plen};
        for (int i = 0; i < hl; i++) begin
            if (hl > 8)
                b = 8'($urandom);
            else if (cur_cfg.header_le)
                b = val[8*i +: 8];
            else
                b = val[8*(hl-1-i) +: 8];
            send_byte(b);
        end
        if (plen <= 60)
            repeat (plen) send_byte(8'($urandom));
    endtask

    task automatic send_line();
        int         len;
        logic [7:0] b;
        len = $urandom_range(0, 25);
        repeat (len) begin
            b = 8'($urandom);
            if (b == NEWLINE)
                b = b ^ 8'h80;
            send_byte(b);
        end
        if ($urandom_range(0, 99) < 85)
            send_byte(NEWLINE);
    endtask

    task automatic random_config();
        int          r;
        logic [30:0] v;
        r = $urandom_range(0, 19);
        v = 31'($urandom);
        if (r == 0)
            v[1:0] = MODE_BAD;
        else
            v[1:0] = t_mode'((r % 3));
        write_reg(REG_FRAME_MODE, v);

        r = $urandom_range(0, 99);
        v = 31'($urandom);
        if (r < 20)
            v[15:0] = '0;
        else if (r < 90)
            v[15:0] = 16'($urandom_range(1, 12));
        else if (r < 95)
            v[15:0] = 16'hFFFF;
        write_reg(REG_FIXED_LEN, v);

        r = $urandom_range(0, 99);
        v = 31'($urandom);
        if (r < 85)
            v[7:0] = 8'($urandom_range(1, 8));
        else if (r < 90)
            v[7:0] = '0;
        else if (r < 97)
            v[7:0] = 8'($urandom_range(9, 12));
        else
            v[7:0] = 8'($urandom_range(9, 255));
        write_reg(REG_HDR_BYTES, v);

        write_reg(REG_HDR_LE, 31'($urandom));

        r = $urandom_range(0, 99);
        if (r < 50)
            v = '0;
        else if (r < 80)
            v = 31'($urandom_range(1, 40));
        else if (r < 90)
            v = LEN_MAX;
        else
            v = 31'($urandom);
        write_reg(REG_MAX_PAYLOAD, v);

        r = $urandom_range(0, 99);
        if (r < 40)
            v = '0;
        else if (r < 85)
            v = 31'($urandom_range(1, 20));
        else if (r < 90)
            v = LEN_MAX;
        else
            v = 31'($urandom);
        write_reg(REG_LINE_LIMIT, v);
    endtask

    // result side: compare against the oldest expectation
    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            frames_checked++;
            if (pending_frames.size() == 0) begin
                $error("unexpected result: status %0d length %0d truncated %0d",
                       res_ch.frame_status, res_ch.packet_length, res_ch.was_truncated);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                if (res_ch.frame_status !== want.status) begin
                    $error("frame_status: expected %0d, got %0d",
                           want.status, res_ch.frame_status);
                    mismatches++;
                end
                if (res_ch.packet_length !== want.length) begin
                    $error("packet_length: expected %0d, got %0d",
                           want.length, res_ch.packet_length);
                    mismatches++;
                end
                if (res_ch.was_truncated !== want.truncated) begin
                    $error("was_truncated: expected %0d, got %0d",
                           want.truncated, res_ch.was_truncated);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off while requests pile up
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!squeeze_done && frames_checked >= SQUEEZE_AT && rx_ch.valid) begin
                squeeze_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYC) @(negedge clk);
                res_ch.ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    res_ch.ready <= 1'b1;
                end else begin
                    res_ch.ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    initial begin
        int rand_start;
        int quota;
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        frames_checked = 0;
        mismatches     = 0;
        bytes_sent     = 0;
        calm           = 1'b0;
        squeeze_done   = 1'b0;
        model_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: raw mode, each byte alone
        add_rx(8'h00, 1'b1, ST_DONE, 31'd1);
        add_rx(8'hFF, 1'b1, ST_DONE, 31'd1);
        add_cfg(REG_FRAME_MODE, CFG_DATA_W'(MODE_BAD));
        add_rx(8'h55, 1'b1, ST_ERROR);
        // raw length above the payload maximum
        add_cfg(REG_FRAME_MODE, CFG_DATA_W'(MODE_RAW));
        add_cfg(REG_FIXED_LEN, 31'd3);
        add_cfg(REG_MAX_PAYLOAD, 31'd2);
        add_rx(8'h12, 1'b1, ST_ERROR);
        add_cfg(REG_MAX_PAYLOAD, 31'd0);
        add_rx(8'h01, 1'b1, ST_NEED);
        add_rx(8'h80, 1'b1, ST_NEED);
        add_rx(8'h7F, 1'b1, ST_DONE, 31'd3);
        // leave a raw packet open, finish it as a line
        add_cfg(REG_FIXED_LEN, 31'hFFFF);
        add_rx(8'hAA, 1'b1, ST_NEED);
        add_cfg(REG_FRAME_MODE, CFG_DATA_W'(MODE_LINE));
        add_rx(NEWLINE, 1'b1, ST_DONE, 31'd2);
        // zero payload header
        add_cfg(REG_FRAME_MODE, CFG_DATA_W'(MODE_LEN));
        add_cfg(REG_HDR_BYTES, 31'd2);
        add_cfg(REG_HDR_LE, 31'd0);
        add_rx(8'h00, 1'b1, ST_NEED);
        add_rx(8'h00, 1'b1, ST_DONE, 31'd2);
        // header length above the maximum
        add_cfg(REG_MAX_PAYLOAD, 31'd4);
        add_rx(8'h00, 1'b1, ST_NEED);
        add_rx(8'h05, 1'b1, ST_ERROR);
        // header plus payload overflows the length range
        add_cfg(REG_MAX_PAYLOAD, LEN_MAX);
        add_cfg(REG_HDR_BYTES, 31'd4);
        add_cfg(REG_HDR_LE, 31'd1);
        add_rx(8'hFF, 1'b1, ST_NEED);
        add_rx(8'hFF, 1'b1, ST_NEED);
        add_rx(8'hFF, 1'b1, ST_NEED);
        add_rx(8'h7F, 1'b1, ST_ERROR);
        add_cfg(REG_HDR_BYTES, 31'd0);
        add_rx(8'h33, 1'b1, ST_ERROR);
        add_cfg(REG_HDR_BYTES, 31'd1);
        add_cfg(REG_HDR_LE, 31'd0);
        add_rx(8'h02);
        add_rx(8'h41);
        add_rx(8'h42);
        // truncation, then a newline right at the limit
        add_cfg(REG_FRAME_MODE, CFG_DATA_W'(MODE_LINE));
        add_cfg(REG_LINE_LIMIT, 31'd3);
        add_rx(8'h61, 1'b1, ST_NEED);
        add_rx(8'h62, 1'b1, ST_NEED);
        add_rx(8'h63, 1'b1, ST_DONE, 31'd3, 1'b1);
        add_rx(8'h61);
        add_rx(8'h62);
        add_rx(NEWLINE, 1'b1, ST_DONE, 31'd3, 1'b0);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                quiesce();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_rx(script[i].rx, script[i].typed, script[i].want);
            end
        end

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            quiesce();
            calm = ($urandom_range(0, 4) == 0);
            random_config();
            quota = bytes_sent + int'($urandom_range(20, 80));
            while (bytes_sent < quota) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end else begin
                    case (cur_cfg.mode)
                        MODE_RAW:  send_byte(8'($urandom));
                        MODE_LEN:  send_len_packet();
                        MODE_LINE: send_line();
                        default:   send_byte(8'($urandom));
                    endcase
                end
            end
        end

        quiesce();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/spf_pkg.sv
sv/spf_channels.sv
sv/spf_cfg_regs.sv
sv/spf_core.sv
sv/serial_packet_framer.sv
tb/serial_packet_framer_tb.sv
